// ===== hw/rtl/bilinear_image_scaler_defines.svh =====
// Assertion macros shared by the scaler RTL.
`ifndef BILINEAR_IMAGE_SCALER_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BIS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bis assertion failed");
`define BIS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bis assertion failed");
`else
`define BIS_ASSERT_IMP(label, clk, rst, ante, cons)
`define BIS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/bis_pkg.sv =====
package bis_pkg;
   localparam int FRAC_BITS   = 8;
   localparam int PIX_W       = 8;
   localparam int COORD_W     = 8;                    // log2 of max source size
   localparam int ADDR_W      = 2 * COORD_W;
   localparam int PROD_W      = 12 + COORD_W;
   localparam int DIVIDEND_W  = PROD_W + FRAC_BITS;
   localparam int DIVISOR_W   = 13;
   localparam int DIV_CNT_W   = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIVIDEND_W);
   localparam logic [8:0] SRC_DIM_MAX = 9'd256;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_DST_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_DST_HEIGHT = 2'd3;
endpackage

// ===== hw/rtl/bis_store.sv =====
module bis_store
   import bis_pkg::*;
(
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [PIX_W-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [PIX_W-1:0]  rdata
);
   logic [PIX_W-1:0] mem_ff [2**ADDR_W];
   logic [PIX_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hw/rtl/bis_div.sv =====
`include "bilinear_image_scaler_defines.svh"
module bis_div
   import bis_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic [DIVIDEND_W-1:0] quotient
);
   logic                  busy_ff, busy_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    trial;

   // restoring division, one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = DIV_STEPS;
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   `BIS_ASSERT_NXT(a_div_start, clock, reset, start && !busy_ff, busy_ff)
   `BIS_ASSERT_IMP(a_div_rem, clock, reset, busy_ff && dsr_ff != '0, rem_ff < dsr_ff)
   `BIS_ASSERT_IMP(a_div_cnt, clock, reset, busy_ff, cnt_ff != '0)
endmodule

// ===== hw/rtl/bilinear_image_scaler.sv =====
// Bilinear image scaler.
// Configuration: csr_we writes csr_wdata into register csr_index (0 src_width,
// 1 src_height, 2 dst_width, 3 dst_height) at once; write only while idle.
// Commands: a transfer happens at a clock edge with start high and busy low.
//   Load (req_command 0): writes req_pixel_in at (req_row, req_col); loads
//   outside the source size are dropped; busy stays low, so loads stream at
//   one per cycle and return nothing.
//   Sample (req_command 1): maps the destination point to a source point with
//   8 fraction bits, reads four neighbors and interpolates. busy is high until
//   the result; rsp_valid then strobes rsp_pixel_out for one cycle. The next
//   command may be given in that same cycle.
// Timing is set by the radix-2 coordinate dividers and the four
// reads through the single read port of the image memory.
// The receiver cannot stall; results are simply presented once.
// Reset restores the default sizes and idles the block; the image memory is
// not cleared, so a pixel must be loaded before it is sampled.
`include "bilinear_image_scaler_defines.svh"
module bilinear_image_scaler
   import bis_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic         req_command,
   input  logic [11:0]  req_row,
   input  logic [11:0]  req_col,
   input  logic [7:0]   req_pixel_in,
   output logic         rsp_valid,
   output logic [7:0]   rsp_pixel_out,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [12:0]  csr_wdata
);
   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_MUL  = 8'b0000_0010,
      ST_LOAD = 8'b0000_0100,
      ST_DIV  = 8'b0000_1000,
      ST_READ = 8'b0001_0000,
      ST_LAST = 8'b0010_0000,
      ST_HORZ = 8'b0100_0000,
      ST_VERT = 8'b1000_0000
   } state_type;

   function automatic logic [PIX_W-1:0] lerp(input logic [PIX_W-1:0] p1,
                                             input logic [PIX_W-1:0] p2,
                                             input logic [FRAC_BITS-1:0] f);
      logic [FRAC_BITS:0] inv;
      logic [PIX_W+FRAC_BITS:0] acc;
      inv = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, f};
      acc = (PIX_W+FRAC_BITS+1)'(p1 * inv) + (PIX_W+FRAC_BITS+1)'(p2 * f);
      return acc[PIX_W+FRAC_BITS-1:FRAC_BITS];
   endfunction

   // configuration registers
   logic [8:0]  src_w_ff, src_h_ff;
   logic [12:0] dst_w_ff, dst_h_ff;

   state_type state_ff, state_in;
   logic [11:0] row_ff, col_ff;
   logic [PROD_W-1:0] prod_x_ff, prod_y_ff;
   logic [COORD_W-1:0] x0_ff, x1_ff, y0_ff, y1_ff;
   logic [FRAC_BITS-1:0] fx_ff, fy_ff;
   logic ok_ff;
   logic [1:0] rd_cnt_ff;
   logic [PIX_W-1:0] pix_ff [4];
   logic [PIX_W-1:0] top_ff, bot_ff;
   logic rsp_valid_ff;
   logic [PIX_W-1:0] pixel_out_ff;

   // saturated sizes
   logic [8:0] w_sat, h_sat;
   logic [COORD_W-1:0] w_m1, h_m1;
   logic dx_deg, dy_deg;
   assign w_sat  = (src_w_ff > SRC_DIM_MAX) ? SRC_DIM_MAX : src_w_ff;
   assign h_sat  = (src_h_ff > SRC_DIM_MAX) ? SRC_DIM_MAX : src_h_ff;
   assign w_m1   = (w_sat == '0) ? '0 : COORD_W'(w_sat - 9'd1);
   assign h_m1   = (h_sat == '0) ? '0 : COORD_W'(h_sat - 9'd1);
   assign dx_deg = dst_w_ff < 13'd2;
   assign dy_deg = dst_h_ff < 13'd2;

   logic accept, load_ok;
   assign accept  = start && (state_ff == ST_IDLE);
   assign load_ok = accept && (req_command == CMD_LOAD)
                    && (req_row < {3'd0, h_sat}) && (req_col < {3'd0, w_sat});

   // coordinate dividers, one per axis, run side by side
   logic div_start, div_busy_x, div_busy_y;
   logic [DIVIDEND_W-1:0] q_x, q_y, pos_x, pos_y;
   assign div_start = (state_ff == ST_LOAD);

   bis_div u_div_x (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend({prod_x_ff, {FRAC_BITS{1'b0}}}),
      .divisor(DIVISOR_W'(dst_w_ff - 13'd1)),
      .busy(div_busy_x), .quotient(q_x)
   );
   bis_div u_div_y (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend({prod_y_ff, {FRAC_BITS{1'b0}}}),
      .divisor(DIVISOR_W'(dst_h_ff - 13'd1)),
      .busy(div_busy_y), .quotient(q_y)
   );

   // a degenerate destination axis maps everything to position 0
   assign pos_x = dx_deg ? '0 : q_x;
   assign pos_y = dy_deg ? '0 : q_y;

   localparam int INT_W = DIVIDEND_W - FRAC_BITS;
   logic [INT_W-1:0] ix, iy;
   logic in_img, x_inner, y_inner;
   assign ix      = pos_x[DIVIDEND_W-1:FRAC_BITS];
   assign iy      = pos_y[DIVIDEND_W-1:FRAC_BITS];
   assign in_img  = (ix < INT_W'(w_sat)) && (iy < INT_W'(h_sat));
   // right column / bottom row: second neighbor clamps onto the first,
   // which makes that lerp an exact copy
   assign x_inner = ({1'b0, ix} + (INT_W+1)'(1)) < (INT_W+1)'(w_sat);
   assign y_inner = ({1'b0, iy} + (INT_W+1)'(1)) < (INT_W+1)'(h_sat);

   // image memory read address, neighbors in raster order
   logic [ADDR_W-1:0] rd_addr;
   logic [PIX_W-1:0]  rd_data;
   always_comb begin
      case (rd_cnt_ff)
         2'd0:    rd_addr = {y0_ff, x0_ff};
         2'd1:    rd_addr = {y0_ff, x1_ff};
         2'd2:    rd_addr = {y1_ff, x0_ff};
         2'd3:    rd_addr = {y1_ff, x1_ff};
         default: rd_addr = {y0_ff, x0_ff};
      endcase
   end

   bis_store u_store (
      .clock(clock),
      .we(load_ok),
      .waddr({req_row[COORD_W-1:0], req_col[COORD_W-1:0]}),
      .wdata(req_pixel_in),
      .raddr(rd_addr),
      .rdata(rd_data)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_command == CMD_SAMPLE) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_LOAD;
         ST_LOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (!div_busy_x && !div_busy_y) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (rd_cnt_ff == 2'd3) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: state_in = ST_HORZ;
         ST_HORZ: state_in = ST_VERT;
         ST_VERT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         src_w_ff     <= 9'd256;
         src_h_ff     <= 9'd256;
         dst_w_ff     <= 13'd512;
         dst_h_ff     <= 13'd512;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_VERT);
         if (state_ff == ST_READ) begin
            rd_cnt_ff <= rd_cnt_ff + 2'd1;
         end else begin
            rd_cnt_ff <= '0;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_SRC_WIDTH:  src_w_ff <= csr_wdata[8:0];
               CSR_SRC_HEIGHT: src_h_ff <= csr_wdata[8:0];
               CSR_DST_WIDTH:  dst_w_ff <= csr_wdata;
               CSR_DST_HEIGHT: dst_h_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         row_ff <= req_row;
         col_ff <= req_col;
      end
      if (state_ff == ST_MUL) begin
         prod_x_ff <= PROD_W'(col_ff * w_m1);
         prod_y_ff <= PROD_W'(row_ff * h_m1);
      end
      if (state_ff == ST_DIV) begin
         ok_ff <= in_img;
         x0_ff <= ix[COORD_W-1:0];
         y0_ff <= iy[COORD_W-1:0];
         x1_ff <= x_inner ? COORD_W'(ix[COORD_W-1:0] + 1'b1) : ix[COORD_W-1:0];
         y1_ff <= y_inner ? COORD_W'(iy[COORD_W-1:0] + 1'b1) : iy[COORD_W-1:0];
         fx_ff <= pos_x[FRAC_BITS-1:0];
         fy_ff <= pos_y[FRAC_BITS-1:0];
      end
      if (state_ff == ST_READ && rd_cnt_ff != 2'd0) begin
         pix_ff[rd_cnt_ff - 2'd1] <= rd_data;
      end
      if (state_ff == ST_LAST) begin
         pix_ff[3] <= rd_data;
      end
      if (state_ff == ST_HORZ) begin
         top_ff <= lerp(pix_ff[0], pix_ff[1], fx_ff);
         bot_ff <= lerp(pix_ff[2], pix_ff[3], fx_ff);
      end
      if (state_ff == ST_VERT) begin
         pixel_out_ff <= ok_ff ? lerp(top_ff, bot_ff, fy_ff) : '0;
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = pixel_out_ff;

   `BIS_ASSERT_NXT(a_sample_busy, clock, reset, accept && req_command == CMD_SAMPLE, busy)
   `BIS_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid_ff, state_ff == ST_IDLE)
   `BIS_ASSERT_IMP(a_rsp_zero, clock, reset, rsp_valid_ff && !ok_ff, pixel_out_ff == '0)
endmodule

// ===== tb/bilinear_image_scaler_checker.sv =====
module bilinear_image_scaler_checker
   import bis_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_command,
   input  logic [11:0] req_row,
   input  logic [11:0] req_col,
   input  logic [7:0]  req_pixel_in,
   input  logic        rsp_valid,
   input  logic [7:0]  rsp_pixel_out,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          samples_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0]  image_mem [0:65535];
   logic [8:0]  src_w, src_h;
   logic [12:0] dst_w, dst_h;
   logic [7:0]  pixel_queue [$];

   function automatic int unsigned clamp_dim(logic [8:0] v);
      return (v > SRC_DIM_MAX) ? 256 : int'(v);
   endfunction

   // fixed-point source position, 8 fraction bits
   function automatic longint unsigned src_pos(int unsigned d, int unsigned dd,
                                               int unsigned s);
      if (dd < 2 || s == 0)
         return 0;
      return ((longint'(d) * (s - 1)) << FRAC_BITS) / (dd - 1);
   endfunction

   function automatic int unsigned blend(int unsigned a, int unsigned b, int unsigned f);
      return (a * (256 - f) + b * f) >> FRAC_BITS;
   endfunction

   function automatic int unsigned px(int unsigned y, int unsigned x);
      return image_mem[y * 256 + x];
   endfunction

   function automatic logic [7:0] interp_pixel(int unsigned r, int unsigned c);
      int unsigned w, h, x, y, fx, fy, top, bot;
      longint unsigned px_pos, py_pos;
      w = clamp_dim(src_w);
      h = clamp_dim(src_h);
      px_pos = src_pos(c, dst_w, w);
      py_pos = src_pos(r, dst_h, h);
      if ((px_pos >> FRAC_BITS) >= w || (py_pos >> FRAC_BITS) >= h)
         return 8'd0;
      x = px_pos >> FRAC_BITS;
      y = py_pos >> FRAC_BITS;
      fx = px_pos & 8'hFF;
      fy = py_pos & 8'hFF;
      if (x < w - 1 && y < h - 1) begin
         top = blend(px(y, x), px(y, x + 1), fx);
         bot = blend(px(y + 1, x), px(y + 1, x + 1), fx);
         return blend(top, bot, fy);
      end
      if (y < h - 1)
         return blend(px(y, x), px(y + 1, x), fy);    // right column
      if (x < w - 1)
         return blend(px(y, x), px(y, x + 1), fx);    // bottom row
      return px(y, x);                                // corner copy
   endfunction

   always @(posedge clock) begin
      logic [7:0] want;
      if (reset) begin
         src_w = 9'd256;
         src_h = 9'd256;
         dst_w = 13'd512;
         dst_h = 13'd512;
         pixel_queue.delete();
         fail_count = 0;
         samples_checked = 0;
      end else begin
         if (rsp_valid) begin
            if (pixel_queue.size() == 0) begin
               $error("unexpected result: pixel_out actual %0d", rsp_pixel_out);
               fail_count++;
            end else begin
               want = pixel_queue.pop_front();
               samples_checked++;
               if (want !== rsp_pixel_out) begin
                  $error("pixel_out mismatch: expected %0d actual %0d", want, rsp_pixel_out);
                  fail_count++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_SRC_WIDTH:  src_w = csr_wdata[8:0];
               CSR_SRC_HEIGHT: src_h = csr_wdata[8:0];
               CSR_DST_WIDTH:  dst_w = csr_wdata;
               CSR_DST_HEIGHT: dst_h = csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_command == CMD_LOAD) begin
               if (req_row < clamp_dim(src_h) && req_col < clamp_dim(src_w))
                  image_mem[req_row * 256 + req_col] = req_pixel_in;
            end else begin
               pixel_queue.push_back(interp_pixel(req_row, req_col));
            end
         end
      end
      pending = pixel_queue.size();
   end
endmodule

// ===== tb/bilinear_image_scaler_test.sv =====
module bilinear_image_scaler_test;
   import bis_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int NUM_PHASES  = 11;

   logic        clock, reset, start, busy;
   logic        req_command;
   logic [11:0] req_row, req_col;
   logic [7:0]  req_pixel_in;
   logic        rsp_valid;
   logic [7:0]  rsp_pixel_out;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [12:0] csr_wdata;

   int fail_count, pending, samples_checked;
   int cycle_count;
   int load_count;
   bit gaps_on;                    // per-phase: random gaps or back-to-back
   bit loaded [0:65535];           // pixels written so far, never sample an unwritten one
   int cur_w, cur_h, cur_dw, cur_dh;

   bilinear_image_scaler u_dut (
      .clock, .reset, .start, .busy,
      .req_command, .req_row, .req_col, .req_pixel_in,
      .rsp_valid, .rsp_pixel_out,
      .csr_we, .csr_index, .csr_wdata
   );

   bilinear_image_scaler_checker u_checker (
      .clock, .reset, .start, .busy,
      .req_command, .req_row, .req_col, .req_pixel_in,
      .rsp_valid, .rsp_pixel_out,
      .csr_we, .csr_index, .csr_wdata,
      .fail_count, .pending, .samples_checked
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // runaway guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // One command transfer. Called right after the previous transfer edge, so
   // start is either held high (no gap) or dropped once, never both in one step.
   task automatic issue(logic cmd, int r, int c, int p);
      int gap;
      gap = gaps_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_command  <= cmd;
      req_row      <= 12'(r);
      req_col      <= 12'(c);
      req_pixel_in <= 8'(p);
      do @(posedge clock); while (busy);
      if (cmd == CMD_LOAD) begin
         load_count++;
         if (r < cur_h && c < cur_w)
            loaded[r * 256 + c] = 1'b1;
      end
   endtask

   // drain: every sample answered, then margin past the sample latency
   task automatic drain();
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // write all four size registers back to back (we stays high throughout)
   task automatic set_sizes(int sw, int sh, int dw, int dh);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= CSR_SRC_WIDTH;  csr_wdata <= 13'(sw);
      @(posedge clock);
      csr_index <= CSR_SRC_HEIGHT; csr_wdata <= 13'(sh);
      @(posedge clock);
      csr_index <= CSR_DST_WIDTH;  csr_wdata <= 13'(dw);
      @(posedge clock);
      csr_index <= CSR_DST_HEIGHT; csr_wdata <= 13'(dh);
      @(posedge clock);
      csr_we <= 1'b0;
      cur_w  = (sw > 256) ? 256 : sw;
      cur_h  = (sh > 256) ? 256 : sh;
      cur_dw = dw;
      cur_dh = dh;
      @(posedge clock);
   endtask

   // load every not-yet-written pixel of the active source area
   task automatic fill_source();
      for (int r = 0; r < cur_h; r++)
         for (int c = 0; c < cur_w; c++)
            if (!loaded[r * 256 + c])
               issue(CMD_LOAD, r, c, $urandom_range(0, 255));
   endtask

   function automatic int pick_coord(int dim);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return $urandom_range(0, 4095);          // anywhere in the 12-bit range
      if (sel == 1) return (dim >= 1 && dim <= 4096) ? dim - 1 : 4095;
      if (sel == 2) return 0;
      return (dim >= 2) ? $urandom_range(0, dim - 1) : $urandom_range(0, 15);
   endfunction

   int sizes [NUM_PHASES][4] = '{
      '{2, 2, 2, 2},            // 2x2 source and destination
      '{256, 1, 4096, 3},       // widest source, destination width 4096
      '{1, 256, 5, 4096},       // tallest source
      '{300, 1, 600, 7},        // oversized width saturates
      '{7, 5, 13, 9},
      '{1, 1, 4, 4},            // unity source
      '{0, 5, 8, 8},            // zero source width
      '{9, 6, 1, 0},            // degenerate destination
      '{16, 12, 37, 23},
      '{511, 1, 100, 2},        // all-ones width field
      '{33, 12, 8191, 70}       // all-ones destination field
   };

   initial begin
      int per_phase;
      clock = 1'b0; reset = 1'b1; start = 1'b0;
      req_command = CMD_LOAD; req_row = '0; req_col = '0; req_pixel_in = '0;
      csr_we = 1'b0; csr_index = CSR_SRC_WIDTH; csr_wdata = '0;
      cycle_count = 0; load_count = 0; gaps_on = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // source fills add roughly 850 loads on top of these
      per_phase = 550 / NUM_PHASES;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         set_sizes(sizes[ph][0], sizes[ph][1], sizes[ph][2], sizes[ph][3]);
         gaps_on = (ph % 3) != 1;
         fill_source();
         if (ph == 0) begin
            // directed on 2x2 -> 2x2 and beyond: corners, edges, interior, out of range
            issue(CMD_LOAD, 0, 0, 8'h00);
            issue(CMD_LOAD, 0, 1, 8'hFF);
            issue(CMD_LOAD, 1, 0, 8'hFF);
            issue(CMD_LOAD, 1, 1, 8'h80);
            issue(CMD_LOAD, 2, 0, 8'h55);      // outside the source, dropped
            issue(CMD_LOAD, 4095, 4095, 8'hAA);
            issue(CMD_SAMPLE, 0, 0, 8'hFF);
            issue(CMD_SAMPLE, 0, 1, 0);
            issue(CMD_SAMPLE, 1, 0, 0);
            issue(CMD_SAMPLE, 1, 1, 0);
            issue(CMD_SAMPLE, 2, 0, 0);
            issue(CMD_SAMPLE, 0, 2, 0);
            issue(CMD_SAMPLE, 4095, 4095, 0);
            drain();
            set_sizes(2, 2, 3, 3);              // interior and half-pel edges
            issue(CMD_SAMPLE, 1, 1, 0);
            issue(CMD_SAMPLE, 1, 2, 0);
            issue(CMD_SAMPLE, 2, 1, 0);
            issue(CMD_SAMPLE, 2, 2, 0);
            issue(CMD_SAMPLE, 0, 1, 0);
         end
         for (int i = 0; i < per_phase; i++) begin
            if ($urandom_range(0, 1) == 0) begin
               issue(CMD_SAMPLE, pick_coord(cur_dh), pick_coord(cur_dw),
                     $urandom_range(0, 255));
            end else if ($urandom_range(0, 3) != 0 && cur_w > 0 && cur_h > 0) begin
               issue(CMD_LOAD, $urandom_range(0, cur_h - 1), $urandom_range(0, cur_w - 1),
                     $urandom_range(0, 255));
            end else begin
               // anywhere; dropped when off the source
               issue(CMD_LOAD, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 255));
            end
         end
         // sender holds off until the block has answered everything
         drain();
      end

      $display("Ran %0d size settings: %0d loads, %0d samples checked.",
               NUM_PHASES + 1, load_count, samples_checked);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

// ===== bilinear_image_scaler.f =====
+incdir+hw/rtl
hw/rtl/bis_pkg.sv
hw/rtl/bis_store.sv
hw/rtl/bis_div.sv
hw/rtl/bilinear_image_scaler.sv
tb/bilinear_image_scaler_checker.sv
tb/bilinear_image_scaler_test.sv
